// File: rtl/core/lewer_pkg.sv
// Package for the line editor with echo ring: request and status codes,
// character constants, the microcode word layout, the control store and the dispatch table.
// No dependencies.
`default_nettype none

package lewer_pkg;

  // Request kinds carried in the input tuser.
  typedef enum logic [1:0] {
    REQ_RX      = 2'd0,
    REQ_POP     = 2'd1,
    REQ_READ    = 2'd2,
    REQ_RELEASE = 2'd3
  } req_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_REFUSED = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_BEYOND  = 2'd3
  } status_t;

  // Character codes.
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_CTRR  = 8'h12;
  localparam logic [7:0] CH_CTRU  = 8'h15;
  localparam logic [7:0] CH_DEL   = 8'h7f;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CARET = 8'h5e;
  localparam logic [7:0] CH_R     = 8'h52;

  // Source of the byte pushed into the echo ring in a step.
  typedef enum logic [1:0] {
    PS_NONE  = 2'd0,
    PS_CONST = 2'd1,
    PS_CHAR  = 2'd2,
    PS_LINE  = 2'd3
  } psel_t;

  // Datapath action of a step.
  typedef enum logic [3:0] {
    A_NONE        = 4'd0,
    A_EMIT        = 4'd1,
    A_ST_REFUSE   = 4'd2,
    A_RELEASE     = 4'd3,
    A_POP_TAKE    = 4'd4,
    A_ST_EMPTY    = 4'd5,
    A_LINE_RD_REQ = 4'd6,
    A_LINE_TAKE   = 4'd7,
    A_ST_BEYOND   = 4'd8,
    A_CR_STORE    = 4'd9,
    A_DONE_SET    = 4'd10,
    A_IDX_CLR     = 4'd11,
    A_IDX_INC     = 4'd12,
    A_CNT_CLR     = 4'd13,
    A_CNT_DEC     = 4'd14,
    A_CHR_STORE   = 4'd15
  } act_t;

  // Jump conditions.
  typedef enum logic [3:0] {
    C_NONE     = 4'd0,
    C_ALWAYS   = 4'd1,
    C_DISPATCH = 4'd2,
    C_OUT_FREE = 4'd3,
    C_EMPTY    = 4'd4,
    C_BEYOND   = 4'd5,
    C_IDX_END  = 4'd6,
    C_CNT_ZERO = 4'd7,
    C_CNT_FULL = 4'd8
  } cond_t;

  localparam int UPC_W = 5;

  typedef struct packed {
    psel_t            psel;
    logic [7:0]       konst;
    act_t             act;
    cond_t            cond;
    logic             hold;
    logic [UPC_W-1:0] target;
  } uword_t;

  // Step addresses of the control program.
  localparam logic [UPC_W-1:0] U_FETCH   = 5'd0;
  localparam logic [UPC_W-1:0] U_EMIT    = 5'd1;
  localparam logic [UPC_W-1:0] U_REFUSE  = 5'd2;
  localparam logic [UPC_W-1:0] U_RELEASE = 5'd3;
  localparam logic [UPC_W-1:0] U_POP0    = 5'd4;
  localparam logic [UPC_W-1:0] U_POP1    = 5'd5;
  localparam logic [UPC_W-1:0] U_POPE    = 5'd6;
  localparam logic [UPC_W-1:0] U_RD0     = 5'd7;
  localparam logic [UPC_W-1:0] U_RD1     = 5'd8;
  localparam logic [UPC_W-1:0] U_RDE     = 5'd9;
  localparam logic [UPC_W-1:0] U_CR0     = 5'd10;
  localparam logic [UPC_W-1:0] U_CR1     = 5'd11;
  localparam logic [UPC_W-1:0] U_RR0     = 5'd12;
  localparam logic [UPC_W-1:0] U_RR1     = 5'd13;
  localparam logic [UPC_W-1:0] U_RR2     = 5'd14;
  localparam logic [UPC_W-1:0] U_RR3     = 5'd15;
  localparam logic [UPC_W-1:0] U_RRL     = 5'd16;
  localparam logic [UPC_W-1:0] U_RRP     = 5'd17;
  localparam logic [UPC_W-1:0] U_RU0     = 5'd18;
  localparam logic [UPC_W-1:0] U_RUL     = 5'd19;
  localparam logic [UPC_W-1:0] U_RU1     = 5'd20;
  localparam logic [UPC_W-1:0] U_RU2     = 5'd21;
  localparam logic [UPC_W-1:0] U_RU3     = 5'd22;
  localparam logic [UPC_W-1:0] U_RUC     = 5'd23;
  localparam logic [UPC_W-1:0] U_DEL0    = 5'd24;
  localparam logic [UPC_W-1:0] U_DEL1    = 5'd25;
  localparam logic [UPC_W-1:0] U_DEL2    = 5'd26;
  localparam logic [UPC_W-1:0] U_DEL3    = 5'd27;
  localparam logic [UPC_W-1:0] U_CH0     = 5'd28;
  localparam logic [UPC_W-1:0] U_CH1     = 5'd29;
  localparam logic [UPC_W-1:0] U_CHF     = 5'd30;

  // Builds one control word.
  function automatic uword_t mk(psel_t ps, logic [7:0] k, act_t a, cond_t c,
                                logic h, logic [UPC_W-1:0] t);
    uword_t w;
    w.psel   = ps;
    w.konst  = k;
    w.act    = a;
    w.cond   = c;
    w.hold   = h;
    w.target = t;
    return w;
  endfunction

  // Control store: one word per step. A taken jump goes to target, or to the
  // dispatch entry on C_DISPATCH; an untaken one holds or falls to the next address.
  function automatic uword_t ucode_rom(logic [UPC_W-1:0] a);
    uword_t w;
    case (a)
      U_FETCH:   w = mk(PS_NONE,  8'h00,    A_NONE,        C_DISPATCH, 1'b1, U_FETCH);
      U_EMIT:    w = mk(PS_NONE,  8'h00,    A_EMIT,        C_OUT_FREE, 1'b1, U_FETCH);
      U_REFUSE:  w = mk(PS_NONE,  8'h00,    A_ST_REFUSE,   C_ALWAYS,   1'b0, U_EMIT);
      U_RELEASE: w = mk(PS_NONE,  8'h00,    A_RELEASE,     C_ALWAYS,   1'b0, U_EMIT);
      U_POP0:    w = mk(PS_NONE,  8'h00,    A_NONE,        C_EMPTY,    1'b0, U_POPE);
      U_POP1:    w = mk(PS_NONE,  8'h00,    A_POP_TAKE,    C_ALWAYS,   1'b0, U_EMIT);
      U_POPE:    w = mk(PS_NONE,  8'h00,    A_ST_EMPTY,    C_ALWAYS,   1'b0, U_EMIT);
      U_RD0:     w = mk(PS_NONE,  8'h00,    A_LINE_RD_REQ, C_BEYOND,   1'b0, U_RDE);
      U_RD1:     w = mk(PS_NONE,  8'h00,    A_LINE_TAKE,   C_ALWAYS,   1'b0, U_EMIT);
      U_RDE:     w = mk(PS_NONE,  8'h00,    A_ST_BEYOND,   C_ALWAYS,   1'b0, U_EMIT);
      U_CR0:     w = mk(PS_CONST, CH_CR,    A_CR_STORE,    C_NONE,     1'b0, U_FETCH);
      U_CR1:     w = mk(PS_CONST, CH_LF,    A_DONE_SET,    C_ALWAYS,   1'b0, U_EMIT);
      U_RR0:     w = mk(PS_CONST, CH_CARET, A_IDX_CLR,     C_NONE,     1'b0, U_FETCH);
      U_RR1:     w = mk(PS_CONST, CH_R,     A_NONE,        C_NONE,     1'b0, U_FETCH);
      U_RR2:     w = mk(PS_CONST, CH_CR,    A_NONE,        C_NONE,     1'b0, U_FETCH);
      U_RR3:     w = mk(PS_CONST, CH_LF,    A_NONE,        C_NONE,     1'b0, U_FETCH);
      U_RRL:     w = mk(PS_NONE,  8'h00,    A_NONE,        C_IDX_END,  1'b0, U_EMIT);
      U_RRP:     w = mk(PS_LINE,  8'h00,    A_IDX_INC,     C_ALWAYS,   1'b0, U_RRL);
      U_RU0:     w = mk(PS_NONE,  8'h00,    A_IDX_CLR,     C_NONE,     1'b0, U_FETCH);
      U_RUL:     w = mk(PS_NONE,  8'h00,    A_NONE,        C_IDX_END,  1'b0, U_RUC);
      U_RU1:     w = mk(PS_CONST, CH_BS,    A_NONE,        C_NONE,     1'b0, U_FETCH);
      U_RU2:     w = mk(PS_CONST, CH_SP,    A_NONE,        C_NONE,     1'b0, U_FETCH);
      U_RU3:     w = mk(PS_CONST, CH_BS,    A_IDX_INC,     C_ALWAYS,   1'b0, U_RUL);
      U_RUC:     w = mk(PS_NONE,  8'h00,    A_CNT_CLR,     C_ALWAYS,   1'b0, U_EMIT);
      U_DEL0:    w = mk(PS_NONE,  8'h00,    A_NONE,        C_CNT_ZERO, 1'b0, U_EMIT);
      U_DEL1:    w = mk(PS_CONST, CH_BS,    A_NONE,        C_NONE,     1'b0, U_FETCH);
      U_DEL2:    w = mk(PS_CONST, CH_SP,    A_NONE,        C_NONE,     1'b0, U_FETCH);
      U_DEL3:    w = mk(PS_CONST, CH_BS,    A_CNT_DEC,     C_ALWAYS,   1'b0, U_EMIT);
      U_CH0:     w = mk(PS_NONE,  8'h00,    A_NONE,        C_CNT_FULL, 1'b0, U_CHF);
      U_CH1:     w = mk(PS_CHAR,  8'h00,    A_CHR_STORE,   C_ALWAYS,   1'b0, U_EMIT);
      U_CHF:     w = mk(PS_CONST, CH_LF,    A_NONE,        C_ALWAYS,   1'b0, U_EMIT);
      default:   w = mk(PS_NONE,  8'h00,    A_NONE,        C_ALWAYS,   1'b0, U_FETCH);
    endcase
    return w;
  endfunction

  // Entry step of the routine for an accepted request.
  function automatic logic [UPC_W-1:0] dispatch(req_t req, logic [7:0] ch, logic done);
    logic [UPC_W-1:0] t;
    case (req)
      REQ_RX: begin
        if (done) begin
          t = U_REFUSE;
        end else begin
          case (ch)
            CH_CR:   t = U_CR0;
            CH_CTRR: t = U_RR0;
            CH_CTRU: t = U_RU0;
            CH_DEL:  t = U_DEL0;
            default: t = U_CH0;
          endcase
        end
      end
      REQ_POP:     t = U_POP0;
      REQ_READ:    t = U_RD0;
      REQ_RELEASE: t = U_RELEASE;
      default:     t = U_RELEASE;
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/line_editor_with_echo_ring_unit.sv
// Top level of the line editor with echo ring: microcode sequencer, line store,
// echo ring and output register. Depends on lewer_pkg.
//
// Each request runs as a routine of microcode steps, one step per echo push, with the
// registered line store read between the read request and the take; Ctrl-R and Ctrl-U
// loop over the stored line. A stalled output holds the emit step. One item is worked
// on at a time; tready returns in the same cycle that the result becomes valid.
// Reset (rst, synchronous, active high) empties the line and the ring; the two
// memories are not cleared.
`default_nettype none

module line_editor_with_echo_ring_unit #(
  parameter int BUFFER_DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // s_tdata fields from bit 0: char_in[7:0], line_index[13:8], zero pad[15:14].
  input  wire logic [15:0] s_tdata,
  // s_tuser fields from bit 0: req_type[1:0].
  input  wire logic [1:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // m_tdata fields from bit 0: data_byte[7:0], line_ready[8], line_length[15:9],
  // echo_count[21:16], zero pad[23:22].
  output logic [23:0]      m_tdata,
  // m_tuser fields from bit 0: data_valid[0], status[2:1].
  output logic [2:0]       m_tuser
);
  import lewer_pkg::*;

  localparam int AW  = $clog2(BUFFER_DEPTH);
  localparam int LCW = $clog2(BUFFER_DEPTH + 1);
  localparam int CW  = (LCW > 7) ? LCW : 7;

  // Sequencer state.
  logic [UPC_W-1:0] upc, upc_next;
  uword_t           uw;
  logic             cond_true;

  // Line and ring control state.
  logic [LCW-1:0] cnt;
  logic           done;
  logic [AW-1:0]  head, tail, tail_nxt, head_nxt;
  logic [AW:0]    used_w;
  logic [AW-1:0]  used;

  // Per-item registers.
  logic [7:0]     char_q;
  logic [5:0]     idx_q;
  logic [LCW-1:0] lp;
  logic [7:0]     res_data;
  logic           res_valid;
  status_t        res_status;

  // Memories and their ports.
  logic [7:0]    ring_mem [BUFFER_DEPTH];
  logic [7:0]    line_mem [BUFFER_DEPTH];
  logic [7:0]    ring_q, line_q;
  logic          push_en;
  logic [7:0]    push_byte;
  logic          line_we;
  logic [AW-1:0] line_wa, line_ra;
  logic [7:0]    line_wd;

  logic          accept, out_free, emit, beyond;
  logic [CW-1:0] idx_w, cnt_w;

  assign uw       = ucode_rom(upc);
  assign s_tready = (upc == U_FETCH);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign emit     = (uw.act == A_EMIT) && out_free;

  // Ring pointers and fill level.
  assign tail_nxt = (tail == AW'(BUFFER_DEPTH - 1)) ? '0 : tail + AW'(1);
  assign head_nxt = (head == AW'(BUFFER_DEPTH - 1)) ? '0 : head + AW'(1);
  assign used_w   = (tail >= head) ? ({1'b0, tail} - {1'b0, head})
                                   : ({1'b0, tail} + (AW+1)'(BUFFER_DEPTH) - {1'b0, head});
  assign used     = used_w[AW-1:0];

  // Line read range check.
  assign idx_w  = CW'(idx_q);
  assign cnt_w  = CW'(cnt);
  assign beyond = !((idx_w < cnt_w) && (idx_w < CW'(BUFFER_DEPTH)));

  // Jump condition of the current step.
  always_comb begin
    case (uw.cond)
      C_NONE:     cond_true = 1'b0;
      C_ALWAYS:   cond_true = 1'b1;
      C_DISPATCH: cond_true = accept;
      C_OUT_FREE: cond_true = out_free;
      C_EMPTY:    cond_true = (head == tail);
      C_BEYOND:   cond_true = beyond;
      C_IDX_END:  cond_true = (lp >= cnt);
      C_CNT_ZERO: cond_true = (cnt == '0);
      C_CNT_FULL: cond_true = (cnt >= LCW'(BUFFER_DEPTH - 1));
      default:    cond_true = 1'b1;
    endcase
  end

  // Next step address.
  always_comb begin
    if (cond_true) begin
      if (uw.cond == C_DISPATCH) begin
        upc_next = dispatch(req_t'(s_tuser), s_tdata[7:0], done);
      end else begin
        upc_next = uw.target;
      end
    end else if (uw.hold) begin
      upc_next = upc;
    end else begin
      upc_next = upc + UPC_W'(1);
    end
  end

  // Echo push source; a push into a full ring is dropped.
  always_comb begin
    case (uw.psel)
      PS_CONST: push_byte = uw.konst;
      PS_CHAR:  push_byte = char_q;
      PS_LINE:  push_byte = line_q;
      default:  push_byte = 8'h00;
    endcase
    push_en = (uw.psel != PS_NONE) && (tail_nxt != head);
  end

  // Line store port control.
  assign line_we = (uw.act == A_CHR_STORE) ||
                   ((uw.act == A_CR_STORE) && (cnt < LCW'(BUFFER_DEPTH)));
  assign line_wd = (uw.act == A_CHR_STORE) ? char_q : CH_LF;
  assign line_wa = cnt[AW-1:0];
  assign line_ra = (uw.act == A_LINE_RD_REQ) ? AW'(idx_w) : lp[AW-1:0];

  // Echo ring memory with registered read at the head.
  always_ff @(posedge clk) begin
    if (push_en) begin
      ring_mem[tail] <= push_byte;
    end
    ring_q <= ring_mem[head];
  end

  // Line store memory with registered read.
  always_ff @(posedge clk) begin
    if (line_we) begin
      line_mem[line_wa] <= line_wd;
    end
    line_q <= line_mem[line_ra];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      upc      <= U_FETCH;
      cnt      <= '0;
      done     <= 1'b0;
      head     <= '0;
      tail     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      upc <= upc_next;
      if (push_en) begin
        tail <= tail_nxt;
      end
      case (uw.act)
        A_CR_STORE: begin
          if (cnt < LCW'(BUFFER_DEPTH)) begin
            cnt <= cnt + LCW'(1);
          end
        end
        A_CHR_STORE: cnt <= cnt + LCW'(1);
        A_CNT_DEC:   cnt <= cnt - LCW'(1);
        A_CNT_CLR:   cnt <= '0;
        A_DONE_SET:  done <= 1'b1;
        A_RELEASE: begin
          cnt  <= '0;
          done <= 1'b0;
        end
        A_POP_TAKE:  head <= head_nxt;
        default: begin
        end
      endcase
      // A new result replaces one that leaves in the same cycle.
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Per-item payload registers and the output register.
  always_ff @(posedge clk) begin
    if (accept) begin
      char_q     <= s_tdata[7:0];
      idx_q      <= s_tdata[13:8];
      res_data   <= 8'h00;
      res_valid  <= 1'b0;
      res_status <= ST_OK;
    end
    case (uw.act)
      A_IDX_CLR:   lp <= '0;
      A_IDX_INC:   lp <= lp + LCW'(1);
      A_POP_TAKE: begin
        res_data  <= ring_q;
        res_valid <= 1'b1;
      end
      A_LINE_TAKE: begin
        res_data  <= line_q;
        res_valid <= 1'b1;
      end
      A_ST_REFUSE: res_status <= ST_REFUSED;
      A_ST_EMPTY:  res_status <= ST_EMPTY;
      A_ST_BEYOND: res_status <= ST_BEYOND;
      default: begin
      end
    endcase
    if (emit) begin
      m_tdata <= {2'b00, 6'(used), 7'(cnt), done, res_data};
      m_tuser <= {res_status, res_valid};
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/lewer_checker.sv
// Port-level checker for the line editor with echo ring, and its bind to the top level.
// Depends on lewer_pkg and line_editor_with_echo_ring_unit.
`default_nettype none

module lewer_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [23:0] m_tdata,
  input wire logic [2:0]  m_tuser
);
  import lewer_pkg::*;

  // No result is offered right after reset.
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // A stalled result holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

  // A result without data carries a zero byte.
  a_zero_byte: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata[7:0] == 8'h00))
    else $error("data byte not zero without data");

  // An error status never comes with data.
  a_status_data: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser[2:1] != ST_OK)) |-> !m_tuser[0])
    else $error("data valid with error status");

  // A refused character only happens while a line is ready.
  a_refused_ready: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser[2:1] == ST_REFUSED)) |-> m_tdata[8])
    else $error("refusal without a ready line");

endmodule

bind line_editor_with_echo_ring_unit lewer_checker u_lewer_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
// Testbench for line_editor_with_echo_ring_unit: directed and random request streams,
// each reply checked field by field against a behavioral model of the line editor.
// Depends on lewer_pkg and the unit under test.

module tb;
  import lewer_pkg::*;

  localparam int DEPTH        = 64;
  localparam int RANDOM_ITEMS = 430;
  localparam int LIMIT_CYCLES = 600000;
  localparam int DRAIN_CYCLES = 300;
  localparam int MAX_REPORTS  = 40;

  typedef struct {
    req_t       kind;
    logic [7:0] ch;
    logic [5:0] idx;
  } request_t;

  typedef struct {
    logic [7:0] data_byte;
    logic       data_valid;
    status_t    status;
    logic       line_ready;
    logic [6:0] line_length;
    logic [5:0] echo_count;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // s_tdata fields from bit 0: char_in[7:0], line_index[13:8], zero pad[15:14].
  logic [15:0] s_tdata = '0;
  // s_tuser fields from bit 0: req_type[1:0].
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // m_tdata fields from bit 0: data_byte[7:0], line_ready[8], line_length[15:9],
  // echo_count[21:16], zero pad[23:22].
  logic [23:0] m_tdata;
  // m_tuser fields from bit 0: data_valid[0], status[2:1].
  logic [2:0]  m_tuser;

  line_editor_with_echo_ring_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Editor model state: line store, line count, ready mark and echo ring.
  logic [7:0] line_mem [DEPTH];
  logic [6:0] line_cnt = '0;
  logic       line_rdy = 1'b0;
  logic [7:0] ring_mem [DEPTH];
  logic [5:0] ring_rd = '0;
  logic [5:0] ring_wr = '0;

  int dropped_echoes = 0;
  int full_beeps     = 0;
  int refused_chars  = 0;

  request_t req_queue[$];
  reply_t   expected_replies[$];

  int total_items     = 1;
  int items_sent      = 0;
  int replies_checked = 0;
  int mismatches      = 0;
  int cycles          = 0;

  // Queue one echo byte; the ring keeps one slot free and drops bytes when full.
  function automatic void echo_put(logic [7:0] b);
    logic [5:0] nxt;
    nxt = ring_wr + 6'd1;
    if (nxt == ring_rd) begin
      dropped_echoes++;
    end else begin
      ring_mem[ring_wr] = b;
      ring_wr = nxt;
    end
  endfunction

  function automatic void echo_rubout();
    echo_put(CH_BS);
    echo_put(CH_SP);
    echo_put(CH_BS);
  endfunction

  // Apply one request to the editor model and return the reply it produces.
  function automatic reply_t edit_line_and_echo(request_t rq);
    reply_t r;
    int     i;
    r.data_byte  = 8'h00;
    r.data_valid = 1'b0;
    r.status     = ST_OK;
    case (rq.kind)
      REQ_RX: begin
        if (line_rdy) begin
          r.status = ST_REFUSED;
          refused_chars++;
        end else begin
          case (rq.ch)
            CH_CR: begin
              if (line_cnt < DEPTH) begin
                line_mem[line_cnt[5:0]] = CH_LF;
                line_cnt++;
              end
              echo_put(CH_CR);
              echo_put(CH_LF);
              line_rdy = 1'b1;
            end
            CH_CTRR: begin
              echo_put(CH_CARET);
              echo_put(CH_R);
              echo_put(CH_CR);
              echo_put(CH_LF);
              for (i = 0; i < line_cnt; i++) echo_put(line_mem[i]);
            end
            CH_CTRU: begin
              for (i = 0; i < line_cnt; i++) echo_rubout();
              line_cnt = '0;
            end
            CH_DEL: begin
              if (line_cnt != 0) begin
                echo_rubout();
                line_cnt--;
              end
            end
            default: begin
              if (line_cnt < DEPTH - 1) begin
                echo_put(rq.ch);
                line_mem[line_cnt[5:0]] = rq.ch;
                line_cnt++;
              end else begin
                // Line full: beep with a line feed and keep the line as it is.
                echo_put(CH_LF);
                full_beeps++;
              end
            end
          endcase
        end
      end
      REQ_POP: begin
        if (ring_rd == ring_wr) begin
          r.status = ST_EMPTY;
        end else begin
          r.data_byte  = ring_mem[ring_rd];
          r.data_valid = 1'b1;
          ring_rd++;
        end
      end
      REQ_READ: begin
        if (rq.idx < line_cnt) begin
          r.data_byte  = line_mem[rq.idx];
          r.data_valid = 1'b1;
        end else begin
          r.status = ST_BEYOND;
        end
      end
      default: begin
        line_cnt = '0;
        line_rdy = 1'b0;
      end
    endcase
    r.line_ready  = line_rdy;
    r.line_length = line_cnt;
    r.echo_count  = ring_wr - ring_rd;
    return r;
  endfunction

  // Stimulus builders.
  function automatic void add_request(req_t k, logic [7:0] ch, logic [5:0] idx);
    request_t rq;
    rq.kind = k;
    rq.ch   = ch;
    rq.idx  = idx;
    req_queue.push_back(rq);
  endfunction

  function automatic void add_rx(logic [7:0] ch);
    add_request(REQ_RX, ch, 6'($urandom));
  endfunction

  function automatic void add_pops(int n);
    repeat (n) add_request(REQ_POP, 8'($urandom), 6'($urandom));
  endfunction

  // A random character that is stored rather than treated as an edit key.
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    c = 8'($urandom);
    if (c == CH_CR || c == CH_CTRR || c == CH_CTRU || c == CH_DEL) c = c ^ 8'h40;
    return c;
  endfunction

  function automatic logic [7:0] edit_key();
    logic [7:0] c;
    case ($urandom_range(0, 3))
      0:       c = CH_CR;
      1:       c = CH_CTRR;
      2:       c = CH_CTRU;
      default: c = CH_DEL;
    endcase
    return c;
  endfunction

  // One typed line: characters with a few edits and echo drains, then usually enter,
  // reads of the finished line, a final drain and usually a release.
  function automatic void add_line_session();
    int len;
    int pop_pct;
    int hi;
    int k;
    len     = ($urandom_range(0, 7) == 0) ? $urandom_range(62, 70) : $urandom_range(0, 12);
    pop_pct = ($urandom_range(0, 2) == 0) ? 5 : 65;
    hi      = (len + 2 > DEPTH - 1) ? DEPTH - 1 : len + 2;
    for (k = 0; k < len; k++) begin
      case ($urandom_range(0, 19))
        0:       add_rx(CH_DEL);
        1:       add_rx(CH_CTRR);
        2:       add_rx(($urandom_range(0, 3) == 0) ? CH_CTRU : plain_char());
        default: add_rx(plain_char());
      endcase
      if ($urandom_range(0, 99) < pop_pct) add_pops($urandom_range(1, 3));
    end
    if ($urandom_range(0, 4) == 0) add_request(REQ_READ, 8'($urandom), 6'($urandom_range(0, hi)));
    if ($urandom_range(0, 9) != 0) add_rx(CH_CR);
    if ($urandom_range(0, 3) == 0) add_rx(8'($urandom));
    repeat ($urandom_range(0, 4)) add_request(REQ_READ, 8'($urandom), 6'($urandom_range(0, hi)));
    add_pops($urandom_range(0, 24));
    if ($urandom_range(0, 5) != 0) add_request(REQ_RELEASE, 8'($urandom), 6'($urandom));
  endfunction

  // A short burst of unstructured requests.
  function automatic void add_noise();
    repeat ($urandom_range(1, 6)) begin
      add_request(req_t'($urandom_range(0, 3)),
                  ($urandom_range(0, 2) == 0) ? edit_key() : 8'($urandom),
                  6'($urandom));
    end
  endfunction

  // Directed opening: empty-state corners, every edit key, refusal and release.
  function automatic void add_directed();
    add_request(REQ_POP, 8'h00, 6'h00);
    add_request(REQ_READ, 8'h00, 6'h00);
    add_request(REQ_READ, 8'hff, 6'h3f);
    add_rx(CH_DEL);
    add_rx(CH_CTRU);
    add_request(REQ_RELEASE, 8'h00, 6'h00);
    add_rx(8'h00);
    add_rx(8'hff);
    add_rx(8'h61);
    add_rx(CH_CTRR);
    add_request(REQ_READ, 8'h00, 6'h00);
    add_request(REQ_READ, 8'h00, 6'h02);
    add_request(REQ_READ, 8'h00, 6'h03);
    add_rx(CH_DEL);
    add_rx(CH_CTRU);
    add_rx(8'h5a);
    add_rx(CH_CR);
    add_rx(8'h71);
    add_request(REQ_READ, 8'h00, 6'h01);
    add_rx(CH_CTRR);
    add_request(REQ_RELEASE, 8'hff, 6'h3f);
    add_pops(4);
  endfunction

  // Idle rates per phase: receiver-heavy gaps, then sender-heavy, then none.
  function automatic int sender_idle_pct();
    int ph;
    ph = (items_sent * 3) / total_items;
    return (ph == 0) ? 29 : (ph == 1) ? 55 : 0;
  endfunction

  function automatic int receiver_idle_pct();
    int ph;
    ph = (items_sent * 3) / total_items;
    return (ph == 0) ? 55 : (ph == 1) ? 29 : 0;
  endfunction

  // Driver: on each accepted item, predict its reply, then present the next item.
  always @(posedge clk) begin
    request_t nxt;
    logic     fire;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      fire = s_tvalid && s_tready;
      if (fire) begin
        expected_replies.push_back(edit_line_and_echo(req_queue.pop_front()));
        items_sent <= items_sent + 1;
      end
      if (fire || !s_tvalid) begin
        if (req_queue.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
          nxt = req_queue[0];
          s_tvalid <= 1'b1;
          s_tdata  <= {2'b00, nxt.idx, nxt.ch};
          s_tuser  <= nxt.kind;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // Monitor: compare each accepted reply with the oldest prediction.
  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: reply with no request outstanding, expected none actual %h/%h",
                     $time, m_tdata, m_tuser);
        end else begin
          want = expected_replies.pop_front();
          check_field("data_byte", want.data_byte, m_tdata[7:0]);
          check_field("data_valid", want.data_valid, m_tuser[0]);
          check_field("status", want.status, m_tuser[2:1]);
          check_field("line_ready", want.line_ready, m_tdata[8]);
          check_field("line_length", want.line_length, m_tdata[15:9]);
          check_field("echo_count", want.echo_count, m_tdata[21:16]);
          replies_checked++;
        end
      end
      m_tready <= ($urandom_range(0, 99) >= receiver_idle_pct());
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int directed_items;
    add_directed();
    directed_items = req_queue.size();
    // Mostly well-formed lines, with some unstructured bursts mixed in.
    while (req_queue.size() < directed_items + RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 7) add_line_session();
      else add_noise();
    end
    // The last session is cut short so the stream keeps its planned length.
    while (req_queue.size() > directed_items + RANDOM_ITEMS) void'(req_queue.pop_back());
    total_items = req_queue.size();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (req_queue.size() != 0 || expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d replies for %0d requests (%0d directed).",
             replies_checked, total_items, directed_items);
    $display("Saw %0d refused characters, %0d full-line beeps, %0d dropped echo bytes.",
             refused_chars, full_beeps, dropped_echoes);
    if (mismatches == 0 && expected_replies.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/lewer_pkg.sv
rtl/core/line_editor_with_echo_ring_unit.sv
rtl/core/lewer_checker.sv
tb/tb.sv
